[rtl/core/rti_pkg.sv]
// rti_pkg: widths, stage counts, register codes and helpers for the
// ray/triangle intersection pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

  // Coordinate format: signed fixed point, COORD_W bits, FRAC_W fraction bits
  localparam int COORD_W  = 21;
  localparam int FRAC_W   = 11;
  localparam int PACK_W   = 3 * COORD_W;

  // Edge / difference vectors and the products built from them
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int NRM_W    = PROD_W + 1;
  localparam int CRS_W    = NRM_W - FRAC_W;
  localparam int DPROD_W  = EDGE_W + CRS_W;
  localparam int DOT_W    = DPROD_W + 2;

  // Distance path
  localparam int DIST_W     = 23;
  localparam int TQ_W       = DIST_W - 1;
  localparam int DIST_FRAC  = 11;
  localparam int DDIV_STEPS = TQ_W;
  localparam int MIND_W     = 22;
  localparam int THR_W      = 10;
  localparam int CFG_W      = MIND_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic signed [DIST_W-1:0] FAR_Q       = DIST_W'(2048000);
  localparam logic [MIND_W-1:0]        MIN_DIST_RST = MIND_W'(3);
  localparam logic [THR_W-1:0]         PAR_THR_RST  = THR_W'(1);

  // Normal path
  localparam int MAG_W      = NRM_W - 1;
  localparam int SMAG_W     = 30;
  localparam int SHIFT_MAX  = MAG_W - SMAG_W;
  localparam int SHAMT_W    = $clog2(SHIFT_MAX + 1);
  localparam int SQR_W      = 2 * SMAG_W;
  localparam int SUM_W      = SQR_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int NORM_FRAC  = 14;
  localparam int NQ_W       = NORM_FRAC + 1;
  localparam int NDIV_STEPS = NQ_W;
  localparam int NUM_W      = SMAG_W + NORM_FRAC + 1;
  localparam int NCOMP_W    = 16;
  localparam int NDP_W      = NCOMP_W + EDGE_W;
  localparam int NDOT_W     = NDP_W + 2;

  localparam logic [NQ_W-1:0] NORM_ONE = NQ_W'(16384);

  // Pipeline bookkeeping: front stages, sqrt, prep, divide, sign, product, out
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_LAT  = FRONT_STAGES + SQRT_STEPS + 1 + NDIV_STEPS + 2 + 1;
  localparam int VLD_N     = PIPE_LAT - 1;
  localparam int DLY       = SQRT_STEPS + 1 + NDIV_STEPS + 2 - (DDIV_STEPS + 1);

  // Rotation of vector indices for cross products
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST = 1'b0,
    CFG_PAR_THR  = 1'b1
  } cfg_reg_t;

  typedef logic signed [EDGE_W-1:0] evec_t [0:2];

  // Split a packed x/y/z word and sign-extend each component to EDGE_W
  function automatic evec_t unpack3(input logic [PACK_W-1:0] p);
    evec_t v;
    v[0] = EDGE_W'($signed(p[3*COORD_W-1:2*COORD_W]));
    v[1] = EDGE_W'($signed(p[2*COORD_W-1:COORD_W]));
    v[2] = EDGE_W'($signed(p[COORD_W-1:0]));
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ray_triangle_intersect.sv]
// ray_triangle_intersect: fully pipelined Moller-Trumbore ray/triangle test.
// Depends on rti_pkg.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------------
//  in      | in_ray_origin .. in_max_distance       | beat taken when start && !busy
//  out     | out_hit, out_distance, out_normal_x/y/z| one-cycle beat on out_valid
//  cfg     | cfg_we, cfg_index, cfg_data            | write on cfg_we, no wait
//
// One beat enters per cycle; busy stays low, the pipeline never stalls.
// The longest path runs through the 31-step square root and the 15-step
// normal divide chain.
// The 22-step distance divider runs alongside and is delayed to line up.
// Synchronous reset clears the valid chain and presets the config registers only.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_intersect
  import rti_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [PACK_W-1:0]         in_ray_origin,
  input  wire logic [PACK_W-1:0]         in_ray_direction,
  input  wire logic [PACK_W-1:0]         in_vertex_a,
  input  wire logic [PACK_W-1:0]         in_vertex_b,
  input  wire logic [PACK_W-1:0]         in_vertex_c,
  input  wire logic signed [DIST_W-1:0]  in_max_distance,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic signed [DIST_W-1:0]       out_distance,
  output logic signed [NCOMP_W-1:0]      out_normal_x,
  output logic signed [NCOMP_W-1:0]      out_normal_y,
  output logic signed [NCOMP_W-1:0]      out_normal_z,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MIND_W-1:0] min_dist_r;
  logic [THR_W-1:0]  par_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
      par_thr_r  <= PAR_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_DIST: min_dist_r <= cfg_data[MIND_W-1:0];
        CFG_PAR_THR:  par_thr_r  <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // The pipeline advances every cycle, so a beat is always taken
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid chain: one bit per stage from the edge stage to the product stage
  logic [VLD_N-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[VLD_N-2:0], accept};
      out_valid <= vld_r[VLD_N-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: unpack, form edges e1 = b - a, e2 = c - a, s = o - a
  // ---------------------------------------------------------------------
  evec_t o_w, d_w, a_w, b_w, c_w;
  logic signed [EDGE_W-1:0] e1_a_r [0:2];
  logic signed [EDGE_W-1:0] e2_a_r [0:2];
  logic signed [EDGE_W-1:0] s_a_r  [0:2];
  logic signed [EDGE_W-1:0] d_a_r  [0:2];
  logic signed [DIST_W-1:0] maxd_a_r;

  always_comb begin
    o_w = unpack3(in_ray_origin);
    d_w = unpack3(in_ray_direction);
    a_w = unpack3(in_vertex_a);
    b_w = unpack3(in_vertex_b);
    c_w = unpack3(in_vertex_c);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_a_r[i] <= b_w[i] - a_w[i];
      e2_a_r[i] <= c_w[i] - a_w[i];
      s_a_r[i]  <= o_w[i] - a_w[i];
      d_a_r[i]  <= d_w[i];
    end
    maxd_a_r <= in_max_distance;
  end

  // ---------------------------------------------------------------------
  // Stage B: cross product terms for p = d x e2, q = s x e1, n = e1 x e2
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0] pp_p_b_r [0:2][0:1];
  logic signed [PROD_W-1:0] pp_q_b_r [0:2][0:1];
  logic signed [PROD_W-1:0] pp_n_b_r [0:2][0:1];
  logic signed [EDGE_W-1:0] e1_b_r [0:2];
  logic signed [EDGE_W-1:0] e2_b_r [0:2];
  logic signed [EDGE_W-1:0] s_b_r  [0:2];
  logic signed [EDGE_W-1:0] d_b_r  [0:2];
  logic signed [DIST_W-1:0] maxd_b_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pp_p_b_r[i][0] <= d_a_r[NXT1[i]] * e2_a_r[NXT2[i]];
      pp_p_b_r[i][1] <= d_a_r[NXT2[i]] * e2_a_r[NXT1[i]];
      pp_q_b_r[i][0] <= s_a_r[NXT1[i]] * e1_a_r[NXT2[i]];
      pp_q_b_r[i][1] <= s_a_r[NXT2[i]] * e1_a_r[NXT1[i]];
      pp_n_b_r[i][0] <= e1_a_r[NXT1[i]] * e2_a_r[NXT2[i]];
      pp_n_b_r[i][1] <= e1_a_r[NXT2[i]] * e2_a_r[NXT1[i]];
      e1_b_r[i] <= e1_a_r[i];
      e2_b_r[i] <= e2_a_r[i];
      s_b_r[i]  <= s_a_r[i];
      d_b_r[i]  <= d_a_r[i];
    end
    maxd_b_r <= maxd_a_r;
  end

  // ---------------------------------------------------------------------
  // Stage C: finish cross products; p and q floor-shift by the fraction
  // ---------------------------------------------------------------------
  logic signed [NRM_W-1:0]  pdiff_w [0:2];
  logic signed [NRM_W-1:0]  qdiff_w [0:2];
  logic signed [CRS_W-1:0]  p_c_r [0:2];
  logic signed [CRS_W-1:0]  q_c_r [0:2];
  logic signed [NRM_W-1:0]  n_c_r [0:2];
  logic signed [EDGE_W-1:0] e1_c_r [0:2];
  logic signed [EDGE_W-1:0] e2_c_r [0:2];
  logic signed [EDGE_W-1:0] s_c_r  [0:2];
  logic signed [EDGE_W-1:0] d_c_r  [0:2];
  logic signed [DIST_W-1:0] maxd_c_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdiff_w[i] = NRM_W'(pp_p_b_r[i][0]) - NRM_W'(pp_p_b_r[i][1]);
      qdiff_w[i] = NRM_W'(pp_q_b_r[i][0]) - NRM_W'(pp_q_b_r[i][1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_c_r[i]  <= CRS_W'(pdiff_w[i] >>> FRAC_W);
      q_c_r[i]  <= CRS_W'(qdiff_w[i] >>> FRAC_W);
      n_c_r[i]  <= NRM_W'(pp_n_b_r[i][0]) - NRM_W'(pp_n_b_r[i][1]);
      e1_c_r[i] <= e1_b_r[i];
      e2_c_r[i] <= e2_b_r[i];
      s_c_r[i]  <= s_b_r[i];
      d_c_r[i]  <= d_b_r[i];
    end
    maxd_c_r <= maxd_b_r;
  end

  // ---------------------------------------------------------------------
  // Stage D: dot product terms; normal magnitudes and signs
  // ---------------------------------------------------------------------
  logic signed [DPROD_W-1:0] dp_d_r [0:11];
  logic [MAG_W-1:0]          mag_d_r [0:2];
  logic [2:0]                nneg_d_r;
  logic signed [EDGE_W-1:0]  d_d_r [0:2];
  logic signed [DIST_W-1:0]  maxd_d_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp_d_r[i]     <= e1_c_r[i] * p_c_r[i];
      dp_d_r[3 + i] <= s_c_r[i] * p_c_r[i];
      dp_d_r[6 + i] <= d_c_r[i] * q_c_r[i];
      dp_d_r[9 + i] <= e2_c_r[i] * q_c_r[i];
      mag_d_r[i]    <= n_c_r[i][NRM_W-1] ? MAG_W'(-n_c_r[i]) : MAG_W'(n_c_r[i]);
      nneg_d_r[i]   <= n_c_r[i][NRM_W-1];
      d_d_r[i]      <= d_c_r[i];
    end
    maxd_d_r <= maxd_c_r;
  end

  // ---------------------------------------------------------------------
  // Stage E: sum dot products; scale normal magnitudes below 2^SMAG_W
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0]         big_w;
  logic [SHAMT_W-1:0]       shamt_w;
  logic signed [DOT_W-1:0]  det_e_r, nu_e_r, nv_e_r, nt_e_r;
  logic [SMAG_W-1:0]        sm_e_r [0:2];
  logic [2:0]               nneg_e_r;
  logic signed [EDGE_W-1:0] d_e_r [0:2];
  logic signed [DIST_W-1:0] maxd_e_r;

  always_comb begin
    big_w   = mag_d_r[0] | mag_d_r[1] | mag_d_r[2];
    shamt_w = '0;
    // highest set bit above the target width wins
    for (int k = 1; k <= SHIFT_MAX; k++) begin
      if (big_w[SMAG_W - 1 + k]) shamt_w = SHAMT_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    det_e_r <= DOT_W'(dp_d_r[0]) + DOT_W'(dp_d_r[1])  + DOT_W'(dp_d_r[2]);
    nu_e_r  <= DOT_W'(dp_d_r[3]) + DOT_W'(dp_d_r[4])  + DOT_W'(dp_d_r[5]);
    nv_e_r  <= DOT_W'(dp_d_r[6]) + DOT_W'(dp_d_r[7])  + DOT_W'(dp_d_r[8]);
    nt_e_r  <= DOT_W'(dp_d_r[9]) + DOT_W'(dp_d_r[10]) + DOT_W'(dp_d_r[11]);
    for (int i = 0; i < 3; i++) begin
      sm_e_r[i] <= SMAG_W'(mag_d_r[i] >> shamt_w);
      d_e_r[i]  <= d_d_r[i];
    end
    nneg_e_r <= nneg_d_r;
    maxd_e_r <= maxd_d_r;
  end

  // ---------------------------------------------------------------------
  // Stage F: fold a negative determinant into all numerators; squares
  // ---------------------------------------------------------------------
  logic                     dneg_w;
  logic signed [DOT_W-1:0]  det_f_r, nu_f_r, nv_f_r, nt_f_r;
  logic                     dzero_f_r;
  logic [SQR_W-1:0]         sq_f_r [0:2];
  logic [SMAG_W-1:0]        sm_f_r [0:2];
  logic [2:0]               nneg_f_r;
  logic signed [EDGE_W-1:0] d_f_r [0:2];
  logic signed [DIST_W-1:0] maxd_f_r;

  assign dneg_w = det_e_r[DOT_W-1];

  always_ff @(posedge clk) begin
    det_f_r   <= dneg_w ? -det_e_r : det_e_r;
    nu_f_r    <= dneg_w ? -nu_e_r  : nu_e_r;
    nv_f_r    <= dneg_w ? -nv_e_r  : nv_e_r;
    nt_f_r    <= dneg_w ? -nt_e_r  : nt_e_r;
    dzero_f_r <= (det_e_r == '0);
    for (int i = 0; i < 3; i++) begin
      sq_f_r[i] <= sm_e_r[i] * sm_e_r[i];
      sm_f_r[i] <= sm_e_r[i];
      d_f_r[i]  <= d_e_r[i];
    end
    nneg_f_r <= nneg_e_r;
    maxd_f_r <= maxd_e_r;
  end

  // ---------------------------------------------------------------------
  // Stage G: reject tests; seed the distance divider and the square root
  // ---------------------------------------------------------------------
  logic signed [DOT_W:0]            nuv_w;
  logic [DOT_W+DIST_FRAC-1:0]       ntw_w, detw_w;
  logic                             miss_w;

  always_comb begin
    nuv_w  = (DOT_W+1)'(nu_f_r) + (DOT_W+1)'(nv_f_r);
    ntw_w  = (DOT_W+DIST_FRAC)'($unsigned(nt_f_r));
    detw_w = {$unsigned(det_f_r), {DIST_FRAC{1'b0}}};
    miss_w = dzero_f_r
          || ($unsigned(det_f_r) < DOT_W'(par_thr_r))
          || nu_f_r[DOT_W-1] || (nu_f_r > det_f_r)
          || nv_f_r[DOT_W-1] || (nuv_w > (DOT_W+1)'(det_f_r))
          || nt_f_r[DOT_W-1]
          || (ntw_w >= detw_w);   // integer part above the distance range
  end

  // ---------------------------------------------------------------------
  // Distance divider: one restoring step per stage, quotient = t * 2^11
  // ---------------------------------------------------------------------
  logic [DOT_W-1:0]         drem_r [0:DDIV_STEPS];
  logic [TQ_W-1:0]          dquo_r [0:DDIV_STEPS];
  logic [TQ_W-1:0]          dlo_r  [0:DDIV_STEPS];
  logic [DOT_W-1:0]         ddet_r [0:DDIV_STEPS];
  logic                     dmiss_r [0:DDIV_STEPS];
  logic signed [DIST_W-1:0] dmax_r [0:DDIV_STEPS];

  logic [DOT_W:0]   dtrial_w [1:DDIV_STEPS];
  logic             dge_w    [1:DDIV_STEPS];
  logic [DOT_W-1:0] drem_nxt [1:DDIV_STEPS];

  always_comb begin
    for (int j = 1; j <= DDIV_STEPS; j++) begin
      dtrial_w[j] = {drem_r[j-1], dlo_r[j-1][TQ_W-1]};
      dge_w[j]    = dtrial_w[j] >= {1'b0, ddet_r[j-1]};
      drem_nxt[j] = dge_w[j] ? DOT_W'(dtrial_w[j] - {1'b0, ddet_r[j-1]})
                             : DOT_W'(dtrial_w[j]);
    end
  end

  always_ff @(posedge clk) begin
    drem_r[0]  <= DOT_W'($unsigned(nt_f_r) >> DIST_FRAC);
    dquo_r[0]  <= '0;
    dlo_r[0]   <= {nt_f_r[DIST_FRAC-1:0], {(TQ_W-DIST_FRAC){1'b0}}};
    ddet_r[0]  <= $unsigned(det_f_r);
    dmiss_r[0] <= miss_w;
    dmax_r[0]  <= maxd_f_r;
    for (int j = 1; j <= DDIV_STEPS; j++) begin
      drem_r[j]  <= drem_nxt[j];
      dquo_r[j]  <= {dquo_r[j-1][TQ_W-2:0], dge_w[j]};
      dlo_r[j]   <= dlo_r[j-1] << 1;
      ddet_r[j]  <= ddet_r[j-1];
      dmiss_r[j] <= dmiss_r[j-1];
      dmax_r[j]  <= dmax_r[j-1];
    end
  end

  // Range check, then hold the distance verdict until the normal catches up
  logic            hd_hit_r [0:DLY];
  logic [TQ_W-1:0] hd_tq_r  [0:DLY];

  always_ff @(posedge clk) begin
    hd_hit_r[0] <= !dmiss_r[DDIV_STEPS]
                && (dquo_r[DDIV_STEPS] >= min_dist_r)
                && ($signed({1'b0, dquo_r[DDIV_STEPS]}) <= dmax_r[DDIV_STEPS]);
    hd_tq_r[0]  <= dquo_r[DDIV_STEPS];
    for (int j = 1; j <= DLY; j++) begin
      hd_hit_r[j] <= hd_hit_r[j-1];
      hd_tq_r[j]  <= hd_tq_r[j-1];
    end
  end

  // ---------------------------------------------------------------------
  // Square root of the scaled |n|^2: one result bit per stage
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]         sqx_r   [0:SQRT_STEPS];
  logic [SUM_W-1:0]         sqr_r   [0:SQRT_STEPS];
  logic [SMAG_W-1:0]        sqmag_r [0:SQRT_STEPS][0:2];
  logic [2:0]               sqneg_r [0:SQRT_STEPS];
  logic signed [EDGE_W-1:0] sqd_r   [0:SQRT_STEPS][0:2];

  logic [SUM_W-1:0] sbit_w   [1:SQRT_STEPS];
  logic [SUM_W:0]   strial_w [1:SQRT_STEPS];
  logic             sge_w    [1:SQRT_STEPS];
  logic [SUM_W-1:0] sqx_nxt  [1:SQRT_STEPS];
  logic [SUM_W-1:0] sqr_nxt  [1:SQRT_STEPS];

  always_comb begin
    for (int j = 1; j <= SQRT_STEPS; j++) begin
      sbit_w[j]   = SUM_W'(1) << (2 * (ROOT_W - j));
      strial_w[j] = {1'b0, sqr_r[j-1]} + {1'b0, sbit_w[j]};
      sge_w[j]    = {1'b0, sqx_r[j-1]} >= strial_w[j];
      sqx_nxt[j]  = sge_w[j] ? SUM_W'({1'b0, sqx_r[j-1]} - strial_w[j]) : sqx_r[j-1];
      sqr_nxt[j]  = sge_w[j] ? (sqr_r[j-1] >> 1) + sbit_w[j] : sqr_r[j-1] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r[0]   <= SUM_W'(sq_f_r[0]) + SUM_W'(sq_f_r[1]) + SUM_W'(sq_f_r[2]);
    sqr_r[0]   <= '0;
    sqneg_r[0] <= nneg_f_r;
    for (int i = 0; i < 3; i++) begin
      sqmag_r[0][i] <= sm_f_r[i];
      sqd_r[0][i]   <= d_f_r[i];
    end
    for (int j = 1; j <= SQRT_STEPS; j++) begin
      sqx_r[j]   <= sqx_nxt[j];
      sqr_r[j]   <= sqr_nxt[j];
      sqneg_r[j] <= sqneg_r[j-1];
      for (int i = 0; i < 3; i++) begin
        sqmag_r[j][i] <= sqmag_r[j-1][i];
        sqd_r[j][i]   <= sqd_r[j-1][i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Normal divide: (mag * 2^14 + len / 2) / len, one quotient bit a stage
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] len_w;
  logic [NUM_W-1:0]  num_w [0:2];

  always_comb begin
    len_w = ROOT_W'(sqr_r[SQRT_STEPS]);
    for (int i = 0; i < 3; i++) begin
      num_w[i] = (NUM_W'(sqmag_r[SQRT_STEPS][i]) << NORM_FRAC) + NUM_W'(len_w >> 1);
    end
  end

  logic [ROOT_W-1:0]        ndrem_r [0:NDIV_STEPS][0:2];
  logic [NQ_W-1:0]          ndquo_r [0:NDIV_STEPS][0:2];
  logic [NQ_W-1:0]          ndlo_r  [0:NDIV_STEPS][0:2];
  logic [ROOT_W-1:0]        ndlen_r [0:NDIV_STEPS];
  logic                     ndzero_r[0:NDIV_STEPS];
  logic [2:0]               ndneg_r [0:NDIV_STEPS];
  logic signed [EDGE_W-1:0] ndd_r   [0:NDIV_STEPS][0:2];

  logic [ROOT_W:0]   ntrial_w [1:NDIV_STEPS][0:2];
  logic              nge_w    [1:NDIV_STEPS][0:2];
  logic [ROOT_W-1:0] ndrem_nxt[1:NDIV_STEPS][0:2];

  always_comb begin
    for (int j = 1; j <= NDIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        ntrial_w[j][i]  = {ndrem_r[j-1][i], ndlo_r[j-1][i][NQ_W-1]};
        nge_w[j][i]     = ntrial_w[j][i] >= {1'b0, ndlen_r[j-1]};
        ndrem_nxt[j][i] = nge_w[j][i] ? ROOT_W'(ntrial_w[j][i] - {1'b0, ndlen_r[j-1]})
                                      : ROOT_W'(ntrial_w[j][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    ndlen_r[0]  <= len_w;
    ndzero_r[0] <= (len_w == '0);
    ndneg_r[0]  <= sqneg_r[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      ndrem_r[0][i] <= ROOT_W'(num_w[i] >> NQ_W);
      ndquo_r[0][i] <= '0;
      ndlo_r[0][i]  <= NQ_W'(num_w[i]);
      ndd_r[0][i]   <= sqd_r[SQRT_STEPS][i];
    end
    for (int j = 1; j <= NDIV_STEPS; j++) begin
      ndlen_r[j]  <= ndlen_r[j-1];
      ndzero_r[j] <= ndzero_r[j-1];
      ndneg_r[j]  <= ndneg_r[j-1];
      for (int i = 0; i < 3; i++) begin
        ndrem_r[j][i] <= ndrem_nxt[j][i];
        ndquo_r[j][i] <= {ndquo_r[j-1][i][NQ_W-2:0], nge_w[j][i]};
        ndlo_r[j][i]  <= ndlo_r[j-1][i] << 1;
        ndd_r[j][i]   <= ndd_r[j-1][i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sign stage, direction product stage, output register
  // ---------------------------------------------------------------------
  logic [NQ_W-1:0]           nv_w  [0:2];
  logic [NCOMP_W-1:0]        nvw_w [0:2];
  logic signed [NCOMP_W-1:0] nrm_s_r [0:2];
  logic signed [EDGE_W-1:0]  d_s_r   [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ndzero_r[NDIV_STEPS]) begin
        nv_w[i] = '0;
      end else if (ndquo_r[NDIV_STEPS][i] > NORM_ONE) begin
        nv_w[i] = NORM_ONE;
      end else begin
        nv_w[i] = ndquo_r[NDIV_STEPS][i];
      end
      nvw_w[i] = NCOMP_W'(nv_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nrm_s_r[i] <= ndneg_r[NDIV_STEPS][i] ? -$signed(nvw_w[i]) : $signed(nvw_w[i]);
      d_s_r[i]   <= ndd_r[NDIV_STEPS][i];
    end
  end

  logic signed [NDP_W-1:0]   np_m_r  [0:2];
  logic signed [NCOMP_W-1:0] nrm_m_r [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      np_m_r[i]  <= nrm_s_r[i] * d_s_r[i];
      nrm_m_r[i] <= nrm_s_r[i];
    end
  end

  // Flip the normal when it points along the ray; drop it on a miss
  logic signed [NDOT_W-1:0]  ndot_w;
  logic                      flip_w;
  logic                      hit_w;
  logic signed [NCOMP_W-1:0] nfin_w [0:2];

  always_comb begin
    ndot_w = NDOT_W'(np_m_r[0]) + NDOT_W'(np_m_r[1]) + NDOT_W'(np_m_r[2]);
    flip_w = ndot_w > 0;
    hit_w  = hd_hit_r[DLY];
    for (int i = 0; i < 3; i++) begin
      if (!hit_w) begin
        nfin_w[i] = '0;
      end else if (flip_w) begin
        nfin_w[i] = -nrm_m_r[i];
      end else begin
        nfin_w[i] = nrm_m_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit      <= hit_w;
    out_distance <= hit_w ? $signed({1'b0, hd_tq_r[DLY]}) : FAR_Q;
    out_normal_x <= nfin_w[0];
    out_normal_y <= nfin_w[1];
    out_normal_z <= nfin_w[2];
  end

endmodule

`default_nettype wire

[rtl/core/rti_checker.sv]
// rti_checker: port-level checks on the intersection pipeline, bound to the
// top level. Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rti_checker
  import rti_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic                      out_hit,
  input wire logic signed [DIST_W-1:0]  out_distance,
  input wire logic signed [NCOMP_W-1:0] out_normal_x,
  input wire logic signed [NCOMP_W-1:0] out_normal_y,
  input wire logic signed [NCOMP_W-1:0] out_normal_z
);

  // Every taken beat gives a result a fixed latency later
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after accepted beat");

  // No result without a beat taken that latency before
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching beat");

  // A miss reports the far distance and a zero normal
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_distance == FAR_Q && out_normal_x == '0
                                 && out_normal_y == '0 && out_normal_z == '0))
    else $error("miss beat with bad payload");

  // A hit never reports a negative distance
  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_distance[DIST_W-1])
    else $error("hit beat with negative distance");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

`default_nettype wire

[sim/tb_ray_triangle_intersect.sv]
// tb_ray_triangle_intersect: self-checking bench for the ray/triangle pipeline.
// Depends on rti_pkg and ray_triangle_intersect; a local intersection
// predictor in the bench supplies the expected hit, distance and normal.
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam int LATENCY     = 57;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint ONE_Q   = 2048;   // 1.0 in coordinate units

  typedef struct packed {
    logic                     hit;
    logic signed [DIST_W-1:0] tdist;
    logic signed [15:0]       nx;
    logic signed [15:0]       ny;
    logic signed [15:0]       nz;
  } isect_t;

  logic clk, rst_n, start, busy;
  logic [PACK_W-1:0] in_ray_origin, in_ray_direction, in_vertex_a, in_vertex_b, in_vertex_c;
  logic signed [DIST_W-1:0] in_max_distance;
  logic out_valid, out_hit;
  logic signed [DIST_W-1:0] out_distance;
  logic signed [NCOMP_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ray_triangle_intersect dut (.*);

  // Predictor copy of the two registers
  logic [MIND_W-1:0] min_dist_q;
  logic [THR_W-1:0]  par_thr;

  isect_t pending_hits[$];
  int     mismatches;
  int     cycles;
  bit     fail_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Intersection predictor
  // ---------------------------------------------------------------------------
  function automatic void split3(input logic [PACK_W-1:0] p, output longint v[3]);
    v[0] = longint'($signed(p[62:42]));
    v[1] = longint'($signed(p[41:21]));
    v[2] = longint'($signed(p[20:0]));
  endfunction

  function automatic void cross_sh(input longint a[3], input longint b[3],
                                   input int sh, output longint o[3]);
    o[0] = (a[1] * b[2] - a[2] * b[1]) >>> sh;
    o[1] = (a[2] * b[0] - a[0] * b[2]) >>> sh;
    o[2] = (a[0] * b[1] - a[1] * b[0]) >>> sh;
  endfunction

  function automatic longint dot(input longint a[3], input longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic isect_t predict_hit(input logic [PACK_W-1:0] po, pd, pa, pb, pc,
                                         input logic signed [DIST_W-1:0] maxd);
    longint o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], s[3], p[3], q[3], n[3];
    longint det, nu, nv, nt, adet, qi, r, tq;
    longint nrm[3];
    longint unsigned mag[3], len, sq, v;
    isect_t res;
    res = '{hit: 1'b0, tdist: FAR_Q, nx: '0, ny: '0, nz: '0};
    split3(po, o); split3(pd, d); split3(pa, a); split3(pb, b); split3(pc, c);
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      s[i]  = o[i] - a[i];
    end
    cross_sh(d, e2, FRAC_W, p);
    det  = dot(e1, p);
    adet = det < 0 ? -det : det;
    if (adet == 0 || adet < longint'(par_thr)) return res;
    cross_sh(s, e1, FRAC_W, q);
    nu = dot(s, p);
    nv = dot(d, q);
    nt = dot(e2, q);
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt < 0) return res;
    qi = nt / det;
    if (qi > (4194303 >> 11)) return res;
    r  = nt - qi * det;
    tq = qi;
    for (int i = 0; i < 11; i++) begin
      r  = r <<< 1;
      tq = tq <<< 1;
      if (r >= det) begin
        r -= det;
        tq |= 1;
      end
    end
    if (tq < longint'(min_dist_q) || tq > longint'(maxd)) return res;
    cross_sh(e1, e2, 0, n);
    for (int i = 0; i < 3; i++) mag[i] = n[i] < 0 ? -n[i] : n[i];
    while ((mag[0] | mag[1] | mag[2]) >= (64'd1 << 30)) begin
      mag[0] >>= 1; mag[1] >>= 1; mag[2] >>= 1;
    end
    sq  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      v = 0;
      if (len != 0) begin
        v = ((mag[i] << 14) + (len >> 1)) / len;
        if (v > 16384) v = 16384;
      end
      nrm[i] = n[i] < 0 ? -longint'(v) : longint'(v);
    end
    if (dot(nrm, d) > 0)
      for (int i = 0; i < 3; i++) nrm[i] = -nrm[i];
    res.hit   = 1'b1;
    res.tdist = tq[DIST_W-1:0];
    res.nx    = nrm[0][15:0];
    res.ny    = nrm[1][15:0];
    res.nz    = nrm[2][15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted beat, check every result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    isect_t want, got;
    cycles <= cycles + 1;
    if (rst_n && start && !busy)
      pending_hits = {pending_hits,
                      predict_hit(in_ray_origin, in_ray_direction, in_vertex_a,
                                  in_vertex_b, in_vertex_c, in_max_distance)};
    if (rst_n && out_valid) begin
      got = '{hit: out_hit, tdist: out_distance, nx: out_normal_x, ny: out_normal_y,
              nz: out_normal_z};
      if (pending_hits.size() == 0) begin
        fail_seen = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          fail_seen = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit %0b/%0b dist %0d/%0d n (%0d %0d %0d)/(%0d %0d %0d)",
                     want.hit, got.hit, want.tdist, got.tdist, want.nx, want.ny, want.nz,
                     got.nx, got.ny, got.nz);
        end
      end
    end
  end

  // Hard stop if the pipeline hangs
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_triangle_intersect test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic logic [PACK_W-1:0] pack3(input longint x, y, z);
    return {x[20:0], y[20:0], z[20:0]};
  endfunction

  // Send one beat: hold it until taken, then either chain the next beat
  // or drop start for a random gap.
  task automatic send_test(input logic [PACK_W-1:0] o, d, a, b, c,
                           input logic signed [DIST_W-1:0] maxd);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    start            <= 1'b1;
    in_ray_origin    <= o;
    in_ray_direction <= d;
    in_vertex_a      <= a;
    in_vertex_b      <= b;
    in_vertex_c      <= c;
    in_max_distance  <= maxd;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected beat has come back
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MIN_DIST) min_dist_q = val[MIND_W-1:0];
    else                     par_thr    = val[THR_W-1:0];
  endtask

  function automatic longint rand_coord(input longint range);
    return longint'($urandom_range(0, 2 * range)) - range;
  endfunction

  // Aimed test: ray from a random origin toward a point near the triangle,
  // so most of them get past the determinant and barycentric checks.
  task automatic send_aimed();
    longint range, a[3], b[3], c[3], o[3], d[3], w1, w2, tp;
    int sh;
    logic signed [DIST_W-1:0] maxd;
    range = longint'(1) << $urandom_range(3, 17);
    w1 = $urandom_range(0, 1100);
    w2 = $urandom_range(0, 1100 - w1);
    sh = $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_coord(range);
      b[i] = rand_coord(range);
      c[i] = rand_coord(range);
      o[i] = rand_coord(range);
      tp   = a[i] + ((w1 * (b[i] - a[i]) + w2 * (c[i] - a[i])) >>> 10);
      d[i] = (tp - o[i]) >>> sh;
      if ($urandom_range(0, 9) == 0) d[i] = -d[i];
    end
    case ($urandom_range(0, 3))
      0:       maxd = DIST_W'($urandom_range(0, 4194303));
      1:       maxd = -$signed({1'b0, 22'($urandom)});
      default: maxd = 23'sd4194303;
    endcase
    send_test(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]), pack3(a[0], a[1], a[2]),
              pack3(b[0], b[1], b[2]), pack3(c[0], c[1], c[2]), maxd);
  endtask

  function automatic logic [PACK_W-1:0] rand_word();
    return PACK_W'({$urandom, $urandom});
  endfunction

  task automatic send_noise();
    send_test(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              DIST_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [PACK_W-1:0] ta, tb, tc, org, dz, tri_far;
    longint five;
    five = 5 * ONE_Q;
    ta  = pack3(0, 0, five);
    tb  = pack3(4 * ONE_Q, 0, five);
    tc  = pack3(0, 4 * ONE_Q, five);
    org = pack3(ONE_Q, ONE_Q, 0);
    dz  = pack3(0, 0, ONE_Q);
    // clean hit, normal turned to face -z
    send_test(org, dz, ta, tb, tc, 23'sd4194303);
    // positive determinant: same triangle wound the other way
    send_test(org, dz, ta, tc, tb, 23'sd4194303);
    // ray pointing away: negative distance
    send_test(org, pack3(0, 0, -ONE_Q), ta, tb, tc, 23'sd4194303);
    // max distance one below the hit, and exactly at it
    send_test(org, dz, ta, tb, tc, DIST_W'(five - 1));
    send_test(org, dz, ta, tb, tc, DIST_W'(five));
    // negative max distance
    send_test(org, dz, ta, tb, tc, -23'sd1);
    send_test(org, dz, ta, tb, tc, -23'sd4194304);
    // u outside, v outside, u+v beyond the edge
    send_test(pack3(-ONE_Q, ONE_Q, 0), dz, ta, tb, tc, 23'sd4194303);
    send_test(pack3(ONE_Q, -ONE_Q, 0), dz, ta, tb, tc, 23'sd4194303);
    send_test(pack3(3 * ONE_Q, 3 * ONE_Q, 0), dz, ta, tb, tc, 23'sd4194303);
    // parallel ray: zero determinant
    send_test(org, pack3(ONE_Q, 0, 0), ta, tb, tc, 23'sd4194303);
    // far hit beyond the representable range
    tri_far = pack3(0, 0, 1000 * ONE_Q);
    send_test(org, pack3(0, 0, 1), pack3(0, 0, five), tb, tc, 23'sd4194303);
    // degenerate triangle with a small nonzero determinant
    send_test(pack3(0, 0, 1), pack3(0, 0, -1), pack3(0, 0, 0), pack3(1, 1, 0),
              pack3(1, 1, 0), 23'sd4194303);
    // field extremes
    send_test('0, '0, '0, '0, '0, '0);
    send_test('1, '1, '1, '1, '1, '1);
    send_test({3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h100000}}, {3{21'h0FFFFF}},
              {21'h0FFFFF, 21'h100000, 21'h0FFFFF}, 23'sd4194303);
    send_test({3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h0FFFFF}}, {3{21'h100000}},
              tri_far, -23'sd4194304);
    send_test(org, {3{21'h0FFFFF}}, ta, tb, tc, 23'sd4194303);
    drain_pipe();
  endtask

  // Walk the registers through their extremes, with mixed beats at each setting
  task automatic test_register_extremes();
    logic [CFG_W-1:0] mins[4], thrs[4];
    mins = '{22'd0, 22'h3FFFFF, 22'd2048, 22'(MIN_DIST_RST)};
    thrs = '{22'd0, 22'd1023, 22'd512, 22'(PAR_THR_RST)};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_MIN_DIST, mins[k]);
      write_reg(CFG_PAR_THR, thrs[k]);
      for (int i = 0; i < 40; i++)
        if (i % 4 == 3) send_noise();
        else send_aimed();
    end
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_pipe();
        write_reg(CFG_MIN_DIST, CFG_W'($urandom_range(0, 64)));
        write_reg(CFG_PAR_THR, CFG_W'($urandom_range(0, 16)));
      end
      // empty the pipeline now and then
      if ($urandom_range(0, 7) == 0) drain_pipe();
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_aimed();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_ray_origin    = '0;
    in_ray_direction = '0;
    in_vertex_a      = '0;
    in_vertex_b      = '0;
    in_vertex_c      = '0;
    in_max_distance  = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MIN_DIST;
    cfg_data         = '0;
    cycles           = 0;
    mismatches       = 0;
    fail_seen        = 1'b0;
    min_dist_q       = MIN_DIST_RST;
    par_thr          = PAR_THR_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_stream(1350);

    drain_pipe();
    if (!fail_seen && pending_hits.size() == 0) begin
      $display("ray_triangle_intersect test passed");
    end else begin
      $display("ray_triangle_intersect test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rti_pkg.sv
rtl/core/ray_triangle_intersect.sv
rtl/core/rti_checker.sv
sim/tb_ray_triangle_intersect.sv
